FILE: src/becs_pkg.sv
// Shared constants, types and helpers for the bit-transposed packed column
// equality count scan. No dependencies; used by the scan top level and its checker.
package becs_pkg;

	localparam int WORD_W        = 32;
	localparam int LANE_COUNT    = 32;
	localparam int LANE_W        = (LANE_COUNT > 1) ? $clog2(LANE_COUNT) : 1;
	localparam int VALS_PER_LANE = 32;
	localparam int ROW_W         = 5;
	localparam int WIDTH_CFG_W   = 6;
	localparam int POS_W         = 10;
	localparam int HIT_CNT_W     = $clog2(VALS_PER_LANE + 1);
	localparam int BLOCK_W       = 16;
	localparam int COUNT_W       = 48;
	localparam int CFG_IDX_W     = 1;

	localparam logic [CFG_IDX_W-1:0] REG_VALUE_WIDTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MATCH_VALUE = 1'd1;

	localparam logic [WIDTH_CFG_W-1:0] DEF_VALUE_WIDTH = 6'd8;
	localparam logic [WIDTH_CFG_W-1:0] MAX_VALUE_WIDTH = 6'd32;

	typedef logic [WORD_W-1:0]  word_t;
	typedef logic [COUNT_W-1:0] count_t;

	// Clamp the configured width into 1..32.
	function automatic logic [WIDTH_CFG_W-1:0] eff_width(input logic [WIDTH_CFG_W-1:0] w);
		logic [WIDTH_CFG_W-1:0] r;
		r = w;
		if (w == '0)
			r = {{(WIDTH_CFG_W-1){1'b0}}, 1'b1};
		else if (w > MAX_VALUE_WIDTH)
			r = MAX_VALUE_WIDTH;
		return r;
	endfunction

	function automatic word_t width_mask(input logic [WIDTH_CFG_W-1:0] w);
		word_t m;
		if (w >= MAX_VALUE_WIDTH)
			m = '1;
		else
			m = (word_t'(1) << w) - word_t'(1);
		return m;
	endfunction

endpackage

FILE: src/bitpacked_equality_count_scan.sv
// Throughput: one word per cycle while the pipeline runs; the lane word memory is read
// and written on the accept edge, then value match, hit count and block accumulate stages.
// A result item is registered after the word with tlast passes the block accumulate stage.
// The pipeline halts only while a finished result waits and a further result is due.
// Reset: arst_n clears positions, counters, valids and the config registers to
// width 8 and match value 0; the lane word memory is not cleared.
module bitpacked_equality_count_scan (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [becs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [becs_pkg::WORD_W-1:0]         cfg_wdata,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [becs_pkg::WORD_W-1:0]         s_axis_tdata,  // [31:0] packed_word
	input  logic                                s_axis_tlast,  // last_word
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [becs_pkg::COUNT_W-1:0]        m_axis_tdata,  // [47:0] match_count
	output logic                                m_axis_tuser   // [0] partial_dropped
);

	logic [becs_pkg::WIDTH_CFG_W-1:0] width_q;
	becs_pkg::word_t                  match_q;

	logic [becs_pkg::LANE_W-1:0]      lane_q;
	logic [becs_pkg::ROW_W-1:0]       row_q;

	becs_pkg::word_t                  lane_mem [becs_pkg::LANE_COUNT];

	logic                             v_s1, v_s2, v_s3;
	logic                             last_s1, last_s2, last_s3;
	logic                             cmpl_s1, cmpl_s2, cmpl_s3;
	becs_pkg::word_t                  word_s1, prev_s1, mask_s1, tgt_s1;
	logic [becs_pkg::ROW_W-1:0]       row_s1;
	logic [becs_pkg::WIDTH_CFG_W-1:0] w_s1;
	logic [becs_pkg::VALS_PER_LANE-1:0] hits_s2;
	logic [becs_pkg::HIT_CNT_W-1:0]   cnt_s3;

	logic [becs_pkg::BLOCK_W-1:0]     block_q;
	becs_pkg::count_t                 total_q;
	logic                             out_valid_q;
	becs_pkg::count_t                 out_count_q;
	logic                             out_drop_q;

	logic                             en, accept, at_last_lane, cmpl_acc;
	logic [becs_pkg::WIDTH_CFG_W-1:0] w_acc;
	logic [becs_pkg::VALS_PER_LANE-1:0] hits;
	logic [becs_pkg::HIT_CNT_W-1:0]   cnt;
	logic [becs_pkg::BLOCK_W-1:0]     blk_sum;
	logic [becs_pkg::COUNT_W:0]       tot_sum;
	becs_pkg::count_t                 tot_sat;

	assign en            = !(v_s3 && last_s3 && out_valid_q && !m_axis_tready);
	assign s_axis_tready = en;
	assign accept        = s_axis_tvalid && en;

	assign w_acc        = becs_pkg::eff_width(width_q);
	assign at_last_lane = (lane_q == becs_pkg::LANE_W'(becs_pkg::LANE_COUNT - 1));
	assign cmpl_acc     = at_last_lane &&
		(({1'b0, row_q} + becs_pkg::WIDTH_CFG_W'(1)) >= w_acc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= becs_pkg::DEF_VALUE_WIDTH;
			match_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				becs_pkg::REG_VALUE_WIDTH: width_q <= cfg_wdata[becs_pkg::WIDTH_CFG_W-1:0];
				becs_pkg::REG_MATCH_VALUE: match_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_q <= '0;
			row_q  <= '0;
		end else if (accept) begin
			if (s_axis_tlast) begin
				lane_q <= '0;
				row_q  <= '0;
			end else if (at_last_lane) begin
				lane_q <= '0;
				row_q  <= cmpl_acc ? '0 : row_q + becs_pkg::ROW_W'(1);
			end else begin
				lane_q <= lane_q + becs_pkg::LANE_W'(1);
			end
		end
	end

	// Read-first lane memory: fetch the lane's previous row word, store the new one.
	always_ff @(posedge clk) begin
		if (accept) begin
			lane_mem[lane_q] <= s_axis_tdata;
			prev_s1          <= lane_mem[lane_q];
			word_s1          <= s_axis_tdata;
			row_s1           <= row_q;
			w_s1             <= w_acc;
			mask_s1          <= becs_pkg::width_mask(w_acc);
			tgt_s1           <= match_q & becs_pkg::width_mask(w_acc);
			last_s1          <= s_axis_tlast;
			cmpl_s1          <= cmpl_acc;
		end
	end

	always_comb begin
		logic [becs_pkg::POS_W-1:0]       start;
		logic [becs_pkg::POS_W-1:0]       fin;
		logic [becs_pkg::WIDTH_CFG_W-1:0] shamt;
		logic [2*becs_pkg::WORD_W-1:0]    pair;
		becs_pkg::word_t                  v;
		pair = {word_s1, prev_s1};
		for (int p = 0; p < becs_pkg::VALS_PER_LANE; p++) begin
			start = becs_pkg::POS_W'(p) * becs_pkg::POS_W'(w_s1);
			fin   = start + becs_pkg::POS_W'(w_s1) - becs_pkg::POS_W'(1);
			shamt = (start[becs_pkg::POS_W-1:5] == row_s1) ?
				{1'b1, start[4:0]} : {1'b0, start[4:0]};
			v       = becs_pkg::WORD_W'(pair >> shamt);
			hits[p] = (fin[becs_pkg::POS_W-1:5] == row_s1) && ((v & mask_s1) == tgt_s1);
		end
	end

	always_comb begin
		cnt = '0;
		for (int p = 0; p < becs_pkg::VALS_PER_LANE; p++)
			cnt = cnt + becs_pkg::HIT_CNT_W'(hits_s2[p]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hits_s2 <= hits;
			last_s2 <= last_s1;
			cmpl_s2 <= cmpl_s1;
			cnt_s3  <= cnt;
			last_s3 <= last_s2;
			cmpl_s3 <= cmpl_s2;
		end
	end

	assign blk_sum = block_q + becs_pkg::BLOCK_W'(cnt_s3);
	assign tot_sum = {1'b0, total_q} + (becs_pkg::COUNT_W + 1)'(blk_sum);
	assign tot_sat = tot_sum[becs_pkg::COUNT_W] ? '1 : tot_sum[becs_pkg::COUNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_q <= '0;
			total_q <= '0;
		end else if (en && v_s3) begin
			if (last_s3) begin
				block_q <= '0;
				total_q <= '0;
			end else if (cmpl_s3) begin
				block_q <= '0;
				total_q <= tot_sat;
			end else begin
				block_q <= blk_sum;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en && v_s3 && last_s3) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s3 && last_s3) begin
			out_count_q <= cmpl_s3 ? tot_sat : total_q;
			out_drop_q  <= !cmpl_s3;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_count_q;
	assign m_axis_tuser  = out_drop_q;

endmodule

FILE: src/becs_checker.sv
// Port-level checker for the packed column equality count scan, bound to its top level.
// Depends on becs_pkg for the count width.
module becs_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_axis_tready,
	input logic                         m_axis_tvalid,
	input logic                         m_axis_tready,
	input logic [becs_pkg::COUNT_W-1:0] m_axis_tdata,
	input logic                         m_axis_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result item changed while stalled");

	a_in_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input held off without a stalled result item");

	a_out_rise_flow: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tready))
		else $error("result item issued while pipeline was halted");

endmodule

bind bitpacked_equality_count_scan becs_checker u_becs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

FILE: tb/tb_bitpacked_equality_count_scan.sv
`timescale 1ns / 1ps
// Self-checking testbench for bitpacked_equality_count_scan: a directed table, then random
// packed streams under varying widths, targets and handshake pressure. Depends on becs_pkg
// and the scan top level; expected totals come from a local scan model or fixed table rows.
module tb_bitpacked_equality_count_scan;

	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 400000;

	typedef enum logic {STIM_REG, STIM_WORDS} stim_kind_t;

	typedef struct packed {
		becs_pkg::count_t total;
		logic             dropped;
	} scan_result_t;

	typedef struct packed {
		stim_kind_t                       kind;
		logic [becs_pkg::CFG_IDX_W-1:0]   reg_index;
		becs_pkg::word_t                  value;
		logic [15:0]                      words;
		logic                             ends_stream;
		logic                             fixed;
		scan_result_t                     fixed_result;
	} stim_row_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [becs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	becs_pkg::word_t                cfg_wdata = '0;
	logic                           s_axis_tvalid = 1'b0;
	logic                           s_axis_tready;
	becs_pkg::word_t                s_axis_tdata = '0;
	logic                           s_axis_tlast = 1'b0;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready = 1'b0;
	becs_pkg::count_t               m_axis_tdata;
	logic                           m_axis_tuser;

	logic [becs_pkg::WIDTH_CFG_W-1:0] width_reg = becs_pkg::DEF_VALUE_WIDTH;
	becs_pkg::word_t                  target_reg = '0;
	becs_pkg::word_t                  lane_words [becs_pkg::LANE_COUNT] = '{default: '0};
	int unsigned                      lane_pos = 0;
	int unsigned                      row_pos = 0;
	int unsigned                      block_hits = 0;
	becs_pkg::count_t                 total_hits = '0;

	scan_result_t pending_results [$];
	scan_result_t oldest_result;
	stim_row_t    directed [$];
	int unsigned  mismatches = 0;
	int unsigned  cycles = 0;
	int unsigned  sender_idle_pct = 0;
	int unsigned  receiver_stall_pct = 0;
	int unsigned  hold_left = 0;

	int unsigned sender_plan [4] = '{0, 80, 0, 14};
	int unsigned receiver_plan [4] = '{0, 0, 80, 14};
	int unsigned width_plan [8] = '{1, 5, 3, 0, 32, 2, 33, 17};

	bitpacked_equality_count_scan i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #5 clk = ~clk;

	function automatic int unsigned active_width();
		if (width_reg == 0)
			return 1;
		if (width_reg > 32)
			return 32;
		return 32'(width_reg);
	endfunction

	function automatic int unsigned hits_in_word(input becs_pkg::word_t cur,
			input becs_pkg::word_t prev, input int unsigned row, input int unsigned w);
		becs_pkg::word_t m, tgt, v;
		int unsigned     p, first, lastbit, off, n;
		m = (w >= 32) ? {becs_pkg::WORD_W{1'b1}} : becs_pkg::word_t'((33'd1 << w) - 33'd1);
		tgt = target_reg & m;
		n = 0;
		for (p = 0; p < 32; p++) begin
			first = p * w;
			lastbit = first + w - 1;
			off = first % 32;
			if (lastbit / 32 == row) begin
				if (first / 32 == row)
					v = (cur >> off) & m;
				else
					v = ((prev >> off) | (cur << (32 - off))) & m;
				if (v == tgt)
					n++;
			end
		end
		return n;
	endfunction

	task automatic absorb_word(input becs_pkg::word_t word, input logic ends_stream,
			input logic fixed, input scan_result_t fixed_result);
		int unsigned                  w, row;
		logic [becs_pkg::LANE_W-1:0]  lane;
		logic [becs_pkg::COUNT_W:0]   sum;
		logic                         block_done;
		scan_result_t                 r;
		w = active_width();
		lane = becs_pkg::LANE_W'(lane_pos);
		row = row_pos;
		block_done = 1'b0;
		block_hits += hits_in_word(word, lane_words[lane], row, w);
		lane_words[lane] = word;
		if (lane + 1 >= becs_pkg::LANE_COUNT) begin
			lane_pos = 0;
			if (row + 1 >= w) begin
				sum = {1'b0, total_hits} + (becs_pkg::COUNT_W + 1)'(block_hits);
				total_hits = sum[becs_pkg::COUNT_W] ? {becs_pkg::COUNT_W{1'b1}} :
					sum[becs_pkg::COUNT_W-1:0];
				block_hits = 0;
				row_pos = 0;
				block_done = 1'b1;
			end else
				row_pos = row + 1;
		end else
			lane_pos = lane + 1;
		if (ends_stream) begin
			r.total = total_hits;
			r.dropped = ~block_done;
			pending_results.push_back(fixed ? fixed_result : r);
			lane_pos = 0;
			row_pos = 0;
			block_hits = 0;
			total_hits = '0;
		end
	endtask

	task automatic flag_mismatch(input string what, input longint unsigned want,
			input longint unsigned got);
		$display("mismatch %s: expected %0h, got %0h", what, want, got);
		mismatches++;
	endtask

	task automatic send_word(input becs_pkg::word_t word, input logic ends_stream,
			input logic fixed, input scan_result_t fixed_result);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= word;
		s_axis_tlast <= ends_stream;
		do @(posedge clk); while (!s_axis_tready);
		absorb_word(word, ends_stream, fixed, fixed_result);
		@(negedge clk);
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [becs_pkg::CFG_IDX_W-1:0] index,
			input becs_pkg::word_t data);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (index == becs_pkg::REG_VALUE_WIDTH)
			width_reg = data[becs_pkg::WIDTH_CFG_W-1:0];
		else
			target_reg = data;
	endtask

	task automatic add_reg(input logic [becs_pkg::CFG_IDX_W-1:0] index,
			input becs_pkg::word_t data);
		stim_row_t r;
		r = '0;
		r.kind = STIM_REG;
		r.reg_index = index;
		r.value = data;
		directed.push_back(r);
	endtask

	task automatic add_words(input becs_pkg::word_t word, input int unsigned n,
			input logic ends_stream, input logic fixed, input becs_pkg::count_t total,
			input logic dropped);
		stim_row_t r;
		r = '0;
		r.kind = STIM_WORDS;
		r.value = word;
		r.words = 16'(n);
		r.ends_stream = ends_stream;
		r.fixed = fixed;
		r.fixed_result.total = total;
		r.fixed_result.dropped = dropped;
		directed.push_back(r);
	endtask

	// Bits of the target repeated along the lane, aligned to the current row.
	function automatic becs_pkg::word_t stripe_word();
		becs_pkg::word_t r;
		int unsigned     w, b;
		w = active_width();
		for (b = 0; b < 32; b++)
			r[b[4:0]] = target_reg[5'((32 * row_pos + b) % w)];
		return r;
	endfunction

	function automatic becs_pkg::word_t pick_word();
		becs_pkg::word_t r;
		int unsigned     sel;
		sel = $urandom_range(9);
		if (sel < 4)
			r = stripe_word();
		else if (sel == 4)
			r = stripe_word() ^ (becs_pkg::word_t'(1) << $urandom_range(31));
		else if (sel == 5)
			r = '0;
		else if (sel == 6)
			r = '1;
		else
			r = $urandom;
		return r;
	endfunction

	task automatic run_streams(input int unsigned budget);
		int unsigned sent, len, w, i;
		sent = 0;
		while (sent < budget) begin
			w = active_width();
			if (w <= 3 && $urandom_range(9) < 6)
				len = (row_pos + 1 >= w) ? 32 - lane_pos : 32 * (w - row_pos) - lane_pos;
			else
				len = $urandom_range(1, ($urandom_range(3) == 0) ? 80 : 12);
			for (i = 1; i <= len; i++)
				send_word(pick_word(), i == len, 1'b0, '0);
			sent += len;
		end
		// leave a stream open so the next setting lands mid-block
		if ($urandom_range(9) < 3) begin
			len = $urandom_range(1, 16);
			for (i = 0; i < len; i++)
				send_word(pick_word(), 1'b0, 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_bitpacked_equality_count_scan NOT OK");
			$finish;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0)
				flag_mismatch("unexpected result item", 0, 64'(m_axis_tdata));
			else begin
				oldest_result = pending_results.pop_front();
				if (m_axis_tdata !== oldest_result.total)
					flag_mismatch("match_count", 64'(oldest_result.total),
						64'(m_axis_tdata));
				if (m_axis_tuser !== oldest_result.dropped)
					flag_mismatch("partial_dropped", 64'(oldest_result.dropped),
						64'(m_axis_tuser));
			end
		end
	end

	initial forever begin
		@(negedge clk);
		if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left--;
		end else
			m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	initial begin
		int unsigned     ph, s, i, k, sel;
		stim_row_t       row;
		becs_pkg::word_t target;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		add_words(32'h0000_0000, 1, 1'b1, 1'b1, 48'd0, 1'b1);
		add_reg(becs_pkg::REG_VALUE_WIDTH, 32'd1);
		add_reg(becs_pkg::REG_MATCH_VALUE, 32'd1);
		add_words(32'hFFFF_FFFF, 32, 1'b1, 1'b1, 48'd1024, 1'b0);
		add_reg(becs_pkg::REG_MATCH_VALUE, 32'hFFFF_FFFE);
		add_words(32'h0000_0000, 32, 1'b0, 1'b0, 48'd0, 1'b0);
		add_words(32'h0000_0000, 5, 1'b1, 1'b1, 48'd1024, 1'b1);
		add_reg(becs_pkg::REG_VALUE_WIDTH, 32'd0);
		add_words(32'hAAAA_AAAA, 32, 1'b1, 1'b1, 48'd512, 1'b0);
		add_reg(becs_pkg::REG_VALUE_WIDTH, 32'd63);
		add_reg(becs_pkg::REG_MATCH_VALUE, 32'hFFFF_FFFF);
		add_words(32'hFFFF_FFFF, 3, 1'b1, 1'b1, 48'd0, 1'b1);
		add_reg(becs_pkg::REG_VALUE_WIDTH, 32'd33);
		add_words(32'h1234_5678, 2, 1'b1, 1'b0, 48'd0, 1'b0);
		add_reg(becs_pkg::REG_VALUE_WIDTH, 32'd2);
		add_reg(becs_pkg::REG_MATCH_VALUE, 32'h1);
		add_words(32'h5555_5555, 32, 1'b0, 1'b0, 48'd0, 1'b0);
		add_reg(becs_pkg::REG_VALUE_WIDTH, 32'd1);
		add_words(32'h5555_5555, 32, 1'b1, 1'b0, 48'd0, 1'b0);
		add_reg(becs_pkg::REG_VALUE_WIDTH, 32'd5);
		add_reg(becs_pkg::REG_MATCH_VALUE, 32'h13);
		add_words(32'hDEAD_BEEF, 12, 1'b1, 1'b0, 48'd0, 1'b0);

		for (i = 0; i < directed.size(); i++) begin
			row = directed[i];
			if (row.kind == STIM_REG)
				write_reg(row.reg_index, row.value);
			else
				for (k = 1; k <= row.words; k++)
					send_word(row.value, row.ends_stream && k == row.words, row.fixed,
						row.fixed_result);
		end

		for (ph = 0; ph < 4; ph++) begin
			sender_idle_pct = sender_plan[ph];
			receiver_stall_pct = receiver_plan[ph];
			for (s = 0; s < 2; s++) begin
				sel = $urandom_range(3);
				target = (sel == 0) ? '0 : (sel == 1) ? '1 : $urandom;
				write_reg(becs_pkg::REG_VALUE_WIDTH, width_plan[ph * 2 + s]);
				write_reg(becs_pkg::REG_MATCH_VALUE, target);
				run_streams(16);
			end
		end

		// hold the output off while single-word streams pile up behind it
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		settle();
		hold_left = 300;
		for (i = 0; i < 24; i++)
			send_word(pick_word(), 1'b1, 1'b0, '0);

		settle();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("tb_bitpacked_equality_count_scan OK");
		else
			$display("tb_bitpacked_equality_count_scan NOT OK");
		$finish;
	end

endmodule
